>>> rtl/bvote_pkg.sv
package bvote_pkg;

    // Number of copy fields carried by one request.
    localparam int COPY_FIELDS = 8;

    // Upper bound on the number of copies that may take part in a vote.
    localparam int MAX_COPIES = 8;

    // Effective vote limit: the smaller of MAX_COPIES and the copy fields.
    localparam int COPY_LIMIT = (MAX_COPIES < COPY_FIELDS) ? MAX_COPIES : COPY_FIELDS;

    // Width of a vote count, which must hold COPY_FIELDS itself.
    localparam int CNT_W = $clog2(COPY_FIELDS + 1);

    // Width of the copies_valid field.
    localparam int NVALID_W = 4;

    typedef logic [7:0] byte_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [NVALID_W-1:0] nvalid_t;
    typedef logic [COPY_FIELDS-1:0] copy_mask_t;
    typedef logic [COPY_FIELDS-1:0][7:0] byte_vec_t;

    // What one lane found: its byte value and how many voting copies hold it.
    typedef struct packed {
        byte_t  value;
        count_t count;
    } vote_t;

    typedef vote_t [COPY_FIELDS-1:0] vote_vec_t;

endpackage

>>> rtl/bvote_if.sv
interface bvote_in_if;
    import bvote_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   copy_byte_0;
    byte_t   copy_byte_1;
    byte_t   copy_byte_2;
    byte_t   copy_byte_3;
    byte_t   copy_byte_4;
    byte_t   copy_byte_5;
    byte_t   copy_byte_6;
    byte_t   copy_byte_7;
    nvalid_t copies_valid;
    logic    in_last;

    modport source (
        output valid,
        input  ready,
        output copy_byte_0,
        output copy_byte_1,
        output copy_byte_2,
        output copy_byte_3,
        output copy_byte_4,
        output copy_byte_5,
        output copy_byte_6,
        output copy_byte_7,
        output copies_valid,
        output in_last
    );

    modport sink (
        input  valid,
        output ready,
        input  copy_byte_0,
        input  copy_byte_1,
        input  copy_byte_2,
        input  copy_byte_3,
        input  copy_byte_4,
        input  copy_byte_5,
        input  copy_byte_6,
        input  copy_byte_7,
        input  copies_valid,
        input  in_last
    );

endinterface

interface bvote_out_if;
    import bvote_pkg::*;

    logic   valid;
    logic   ready;
    byte_t  voted_byte;
    count_t vote_total;
    logic   out_last;

    modport source (
        output valid,
        input  ready,
        output voted_byte,
        output vote_total,
        output out_last
    );

    modport sink (
        input  valid,
        output ready,
        input  voted_byte,
        input  vote_total,
        input  out_last
    );

endinterface

>>> rtl/bvote_lane.sv
module bvote_lane (
    input  bvote_pkg::byte_t      own_byte,
    input  bvote_pkg::byte_vec_t  copy_bytes,
    input  bvote_pkg::copy_mask_t copy_mask,
    input  logic                  lane_active,
    output bvote_pkg::vote_t      vote
);
    import bvote_pkg::*;

    // Count the voting copies that hold the same byte as this lane.
    always_comb
    begin
        count_t cnt;
        cnt = '0;
        for (int j = 0; j < COPY_FIELDS; j++)
        begin
            if (copy_mask[j] && (copy_bytes[j] == own_byte))
            begin
                cnt = cnt + count_t'(1);
            end
        end
        vote.value = own_byte;
        vote.count = lane_active ? cnt : '0;
    end

endmodule

>>> rtl/bvote_merge.sv
module bvote_merge (
    input  bvote_pkg::vote_vec_t votes,
    output bvote_pkg::byte_t     voted_byte,
    output bvote_pkg::count_t    vote_total
);
    import bvote_pkg::*;

    // Scan from the lowest lane; only a strictly larger count replaces the
    // current best, so a tie stays with the value first seen.
    always_comb
    begin
        byte_t  best_val;
        count_t best_cnt;
        best_val = '0;
        best_cnt = '0;
        for (int i = 0; i < COPY_FIELDS; i++)
        begin
            if (votes[i].count > best_cnt)
            begin
                best_cnt = votes[i].count;
                best_val = votes[i].value;
            end
        end
        voted_byte = best_val;
        vote_total = best_cnt;
    end

endmodule

>>> rtl/bytewise_plurality_vote_top.sv
// A request accepted at a clock edge is written into the stage one registers; its merge
// result goes into the output register when stage one advances, and drives the outputs.
// Throughput: one request per cycle while the result side accepts, set by the two-register
// pipeline (lane count stage, then the merge stage into the output register).
// Reset: rst_n is asynchronous and active low; it empties both pipeline stages.
// Payload registers are not reset and are ignored while their stage is empty.
module bytewise_plurality_vote_top (
    input  logic       clk,
    input  logic       rst_n,
    bvote_in_if.sink   copies,
    bvote_out_if.source result
);
    import bvote_pkg::*;

    // ------------------------------------------------------------------
    // Request unpacking and the vote mask.
    // ------------------------------------------------------------------
    // The copy fields are gathered into one vector so that every lane can
    // compare its own byte with all the others.
    byte_vec_t  copy_bytes;
    nvalid_t    n_sat;
    copy_mask_t copy_mask;

    assign copy_bytes[0] = copies.copy_byte_0;
    assign copy_bytes[1] = copies.copy_byte_1;
    assign copy_bytes[2] = copies.copy_byte_2;
    assign copy_bytes[3] = copies.copy_byte_3;
    assign copy_bytes[4] = copies.copy_byte_4;
    assign copy_bytes[5] = copies.copy_byte_5;
    assign copy_bytes[6] = copies.copy_byte_6;
    assign copy_bytes[7] = copies.copy_byte_7;

    // A copy count above the limit saturates to the limit. A count of zero
    // leaves every lane inactive, which yields byte zero with zero votes.
    always_comb
    begin
        if (copies.copies_valid > nvalid_t'(COPY_LIMIT))
        begin
            n_sat = nvalid_t'(COPY_LIMIT);
        end
        else
        begin
            n_sat = copies.copies_valid;
        end
        for (int j = 0; j < COPY_FIELDS; j++)
        begin
            copy_mask[j] = nvalid_t'(j) < n_sat;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per copy field, each counting matches of its own byte.
    // ------------------------------------------------------------------
    vote_vec_t lane_votes;

    for (genvar g = 0; g < COPY_FIELDS; g++)
    begin : g_lane
        bvote_lane u_lane (
            .own_byte    (copy_bytes[g]),
            .copy_bytes  (copy_bytes),
            .copy_mask   (copy_mask),
            .lane_active (copy_mask[g]),
            .vote        (lane_votes[g])
        );
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage loads when it is empty or when the
    // stage after it moves on, so a full pipeline still takes a request
    // in every cycle that the result side accepts one.
    // ------------------------------------------------------------------
    logic      s1_valid_reg;
    logic      s1_valid_next;
    vote_vec_t s1_votes_reg;
    logic      s1_last_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    byte_t     out_byte_reg;
    count_t    out_total_reg;
    logic      out_last_reg;

    logic      out_adv;
    logic      s1_adv;

    assign out_adv      = !out_valid_reg || result.ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign copies.ready = s1_adv;

    always_comb
    begin
        s1_valid_next  = s1_adv ? copies.valid : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one holds the lane counts of the request in flight.
    always_ff @(posedge clk)
    begin
        if (copies.valid && s1_adv)
        begin
            s1_votes_reg <= lane_votes;
            s1_last_reg  <= copies.in_last;
        end
    end

    // ------------------------------------------------------------------
    // Merge: the lowest lane with the highest count wins.
    // ------------------------------------------------------------------
    byte_t  merge_byte;
    count_t merge_total;

    bvote_merge u_merge (
        .votes      (s1_votes_reg),
        .voted_byte (merge_byte),
        .vote_total (merge_total)
    );

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_adv)
        begin
            out_byte_reg  <= merge_byte;
            out_total_reg <= merge_total;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.voted_byte = out_byte_reg;
    assign result.vote_total = out_total_reg;
    assign result.out_last   = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An accepted request always lands in stage one.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (copies.valid && copies.ready) |=> s1_valid_reg)
        else $error("accepted request did not reach stage one");

    // A result never claims more votes than the copies that may vote.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_total_reg <= count_t'(COPY_LIMIT)))
        else $error("vote total exceeds copy limit");

    // An empty vote can only come with byte zero.
    a_empty_vote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_total_reg == '0)) |-> (out_byte_reg == '0))
        else $error("empty vote with nonzero byte");

    // While a result stalls and stage one is full, the request side is held.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && s1_valid_reg) |-> !copies.ready)
        else $error("request taken while pipeline is full and stalled");

endmodule

>>> test/bytewise_plurality_vote_top_tb.sv
module bytewise_plurality_vote_top_tb;
    import bvote_pkg::*;

    // Generous bound on the whole run. The slowest correct run is about
    // 1600 requests, each with the longest sender gap, the longest receiver
    // stall and the pipeline latency, plus one long stall and a few drains.
    localparam int CYCLE_LIMIT = 300000;

    // Waiting out these extra cycles at the end catches any result that
    // should not be there.
    localparam int TAIL_CYCLES = 8;

    // The long receiver stall starts once this many votes have been seen.
    localparam int LONG_STALL_AT = 400;
    localparam int LONG_STALL_CYCLES = 150;

    localparam int RANDOM_POSITIONS = 1530;

    // One byte position of a section. hold_for_drain makes the sender wait
    // until every earlier result has come back before it offers this one.
    typedef struct packed {
        byte_vec_t bytes;
        nvalid_t   nvalid;
        logic      last;
        logic      hold_for_drain;
    } position_t;

    typedef struct packed {
        byte_t  voted;
        count_t total;
        logic   last;
    } vote_result_t;

    logic clk;
    logic rst_n;

    bvote_in_if  copies_ch ();
    bvote_out_if result_ch ();

    bytewise_plurality_vote_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .copies (copies_ch.sink),
        .result (result_ch.source)
    );

    position_t    pending_positions[$];
    vote_result_t expected_votes[$];
    position_t    offered_position;

    int mismatch_count = 0;
    int votes_seen = 0;
    int cycle_count = 0;

    // Sender pacing: gap before the next request, and a run of requests
    // that are sent back to back.
    int send_gap = 0;
    int send_calm_left = 0;

    // Receiver pacing, counted in cycles by the receiver itself.
    int stall_left = 0;
    int recv_calm_left = 0;
    bit long_stall_done = 1'b0;

    // Plurality over the leading copies. The count is clamped to the vote
    // limit, a count of zero gives a zero result, and a tie goes to the
    // value that shows up first, because only a strictly larger count can
    // replace the current winner.
    function automatic vote_result_t tally_plurality(input position_t pos);
        vote_result_t res;
        int voters;
        int hits;
        res.voted = '0;
        res.total = '0;
        res.last = pos.last;
        voters = int'(pos.nvalid);
        if (voters > COPY_LIMIT)
            voters = COPY_LIMIT;
        for (int i = 0; i < voters; i++)
        begin
            hits = 0;
            for (int j = 0; j < voters; j++)
            begin
                if (pos.bytes[j] == pos.bytes[i])
                    hits++;
            end
            if (hits > int'(res.total))
            begin
                res.total = count_t'(hits);
                res.voted = pos.bytes[i];
            end
        end
        return res;
    endfunction

    // Queues one directed position, with the copies listed from copy 0 up.
    task automatic add_position(input byte_t c0, input byte_t c1, input byte_t c2,
                                input byte_t c3, input byte_t c4, input byte_t c5,
                                input byte_t c6, input byte_t c7, input int voters,
                                input logic last);
        position_t pos;
        pos.bytes[0] = c0;
        pos.bytes[1] = c1;
        pos.bytes[2] = c2;
        pos.bytes[3] = c3;
        pos.bytes[4] = c4;
        pos.bytes[5] = c5;
        pos.bytes[6] = c6;
        pos.bytes[7] = c7;
        pos.nvalid = nvalid_t'(voters);
        pos.last = last;
        pos.hold_for_drain = 1'b0;
        pending_positions.push_back(pos);
    endtask

    // Damaged copies of one section mostly agree, so most copy bytes are
    // drawn from a small palette. That gives real pluralities and ties.
    // Now and then a byte is fully random, like a corrupted copy. The
    // number of voters is usually 1 to 8. It is sometimes 0, and sometimes
    // above 8 so that the clamp is exercised.
    function automatic position_t random_position();
        position_t pos;
        byte_t palette[4];
        int kinds;
        int pick;
        kinds = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++)
            palette[k] = byte_t'($urandom);
        for (int i = 0; i < COPY_FIELDS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pos.bytes[i] = byte_t'($urandom);
            else
                pos.bytes[i] = palette[$urandom_range(0, kinds - 1)];
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            pos.nvalid = '0;
        else if (pick == 1)
            pos.nvalid = nvalid_t'($urandom_range(9, 15));
        else
            pos.nvalid = nvalid_t'($urandom_range(1, 8));
        pos.last = ($urandom_range(0, 7) == 0);
        pos.hold_for_drain = 1'b0;
        return pos;
    endfunction

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm_left = $urandom_range(16, 48);
        return $urandom_range(0, 8);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is held at the start and then released for good. The driver
    // and the receiver give their outputs known values while it is held.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Builds the stimulus, waits for the block to go quiet and reports.
    initial
    begin
        position_t pos;

        // All copies agree, at both ends of the byte range.
        add_position(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8, 1'b0);
        add_position(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8, 1'b1);
        // All copies differ, so the eight-way tie goes to copy 0.
        add_position(8'h10, 8'h21, 8'h32, 8'h43, 8'h54, 8'h65, 8'h76, 8'h87, 8, 1'b0);
        // No copies vote. The result is zero, but the last flag still passes.
        add_position(8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 0, 1'b1);
        add_position(8'h5A, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 1, 1'b0);
        // Too many copies. The vote is clamped to the eight copy fields.
        add_position(8'h7E, 8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E, 8'h81, 8'h81, 15, 1'b0);
        add_position(8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 9, 1'b1);
        // Four against four. The value first seen at copy 0 wins.
        add_position(8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8, 1'b0);
        add_position(8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8, 1'b0);
        // A tie among later copies. The earlier first occurrence still wins.
        add_position(8'h09, 8'h11, 8'h22, 8'h22, 8'h11, 8'h09, 8'h00, 8'h00, 6, 1'b0);
        // The value that fills the unused copies must not count.
        add_position(8'h01, 8'h02, 8'h02, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 3, 1'b0);
        // The plurality sits in the middle copies.
        add_position(8'h10, 8'h20, 8'h30, 8'h40, 8'h40, 8'h40, 8'h50, 8'h60, 8, 1'b0);
        add_position(8'h3C, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2, 1'b1);
        // A single stray copy 0 is outvoted by the rest.
        add_position(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8, 1'b0);
        add_position(8'h80, 8'h80, 8'h7F, 8'h7F, 8'h7F, 8'h01, 8'hFE, 8'h80, 7, 1'b0);
        add_position(8'h33, 8'h44, 8'h44, 8'h33, 8'h33, 8'h44, 8'h44, 8'h44, 5, 1'b1);
        add_position(8'hE7, 8'h18, 8'hE7, 8'h18, 8'h18, 8'hE7, 8'h00, 8'h00, 4, 1'b0);
        add_position(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8, 1'b1);

        for (int n = 0; n < RANDOM_POSITIONS; n++)
        begin
            pos = random_position();
            // Before the random part, and twice inside it, the sender waits
            // until the pipeline has fully drained.
            if (n == 0 || n == 700 || n == 1200)
                pos.hold_for_drain = 1'b1;
            pending_positions.push_back(pos);
        end

        // Sample away from the rising edge, so that the driver's and the
        // monitor's updates have settled.
        do
            @(negedge clk);
        while (pending_positions.size() != 0 || copies_ch.valid || expected_votes.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("bytewise_plurality_vote_top regression: pass");
        else
            $display("bytewise_plurality_vote_top regression: fail");
        $finish;
    end

    // Driver. When a request is taken, its expected vote is queued. Then,
    // once the bus is free, the driver counts down the gap it drew or
    // offers the next position. A position marked to wait for a drain is
    // held back until no result is outstanding. valid gets at most one
    // nonblocking assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copies_ch.valid <= 1'b0;
            copies_ch.copy_byte_0 <= '0;
            copies_ch.copy_byte_1 <= '0;
            copies_ch.copy_byte_2 <= '0;
            copies_ch.copy_byte_3 <= '0;
            copies_ch.copy_byte_4 <= '0;
            copies_ch.copy_byte_5 <= '0;
            copies_ch.copy_byte_6 <= '0;
            copies_ch.copy_byte_7 <= '0;
            copies_ch.copies_valid <= '0;
            copies_ch.in_last <= 1'b0;
            offered_position <= '0;
            send_gap = 0;
        end
        else
        begin
            if (copies_ch.valid && copies_ch.ready)
                expected_votes.push_back(tally_plurality(offered_position));

            if (!copies_ch.valid || copies_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    copies_ch.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_positions.size() == 0)
                    copies_ch.valid <= 1'b0;
                else if (pending_positions[0].hold_for_drain && expected_votes.size() != 0)
                    copies_ch.valid <= 1'b0;
                else
                begin
                    offered_position <= pending_positions[0];
                    copies_ch.copy_byte_0 <= pending_positions[0].bytes[0];
                    copies_ch.copy_byte_1 <= pending_positions[0].bytes[1];
                    copies_ch.copy_byte_2 <= pending_positions[0].bytes[2];
                    copies_ch.copy_byte_3 <= pending_positions[0].bytes[3];
                    copies_ch.copy_byte_4 <= pending_positions[0].bytes[4];
                    copies_ch.copy_byte_5 <= pending_positions[0].bytes[5];
                    copies_ch.copy_byte_6 <= pending_positions[0].bytes[6];
                    copies_ch.copy_byte_7 <= pending_positions[0].bytes[7];
                    copies_ch.copies_valid <= pending_positions[0].nvalid;
                    copies_ch.in_last <= pending_positions[0].last;
                    copies_ch.valid <= 1'b1;
                    void'(pending_positions.pop_front());
                    send_gap = draw_gap(send_calm_left);
                end
            end
        end
    end

    // Monitor and receiver. Each vote that is taken is checked against the
    // oldest expectation. After each vote the receiver draws a stall. Once
    // in the run it holds ready low for a long stretch, so that the
    // pipeline fills up and pushes back on the sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                votes_seen++;
                if (expected_votes.size() == 0)
                begin
                    $error("vote result with no request outstanding: voted_byte %0h vote_total %0d",
                           result_ch.voted_byte, result_ch.vote_total);
                    mismatch_count++;
                end
                else
                begin
                    if (result_ch.voted_byte !== expected_votes[0].voted)
                    begin
                        $error("voted_byte: expected %0h, actual %0h",
                               expected_votes[0].voted, result_ch.voted_byte);
                        mismatch_count++;
                    end
                    if (result_ch.vote_total !== expected_votes[0].total)
                    begin
                        $error("vote_total: expected %0d, actual %0d",
                               expected_votes[0].total, result_ch.vote_total);
                        mismatch_count++;
                    end
                    if (result_ch.out_last !== expected_votes[0].last)
                    begin
                        $error("out_last: expected %0b, actual %0b",
                               expected_votes[0].last, result_ch.out_last);
                        mismatch_count++;
                    end
                    void'(expected_votes.pop_front());
                end
                stall_left = draw_gap(recv_calm_left);
                if (votes_seen == LONG_STALL_AT && !long_stall_done)
                begin
                    stall_left = LONG_STALL_CYCLES;
                    long_stall_done = 1'b1;
                end
            end

            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bytewise_plurality_vote_top regression: fail");
            $finish;
        end
    end

endmodule
